// ===== hw/rtl/ahp_pkg.sv =====
`timescale 1ns / 1ps

package ahp_pkg;

    localparam int FIXED_HEADER_BYTES = 32;
    localparam int POS_W              = $clog2(FIXED_HEADER_BYTES);
    localparam int QUEUE_DEPTH        = 2;
    localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [15:0] MIN_HEAD_SIZE = 16'd7;
    localparam logic [7:0]  FILE_TYPE_RST = 8'd116;

    // Header positions that take no part in the CRC lie below this one.
    localparam logic [POS_W-1:0] CRC_FIRST_POS = POS_W'(2);
    localparam logic [POS_W-1:0] LAST_POS      = POS_W'(FIXED_HEADER_BYTES - 1);

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CRC_BAD = 3'd1;
    localparam logic [2:0] ST_BROKEN  = 3'd2;
    localparam logic [2:0] ST_OTHER   = 3'd3;
    localparam logic [2:0] ST_END     = 3'd4;

    // Kinds of queued entries.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] block_flags;
        logic [15:0] header_size;
        logic [31:0] packed_size;
        logic [31:0] unpacked_size;
        logic [7:0]  host_system;
        logic [31:0] content_crc;
        logic [31:0] packed_time;
        logic [7:0]  unpack_version;
        logic [7:0]  pack_method;
        logic [15:0] name_length;
        logic [31:0] attributes;
        logic [2:0]  status;
    } t_out_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_qent;

    // One byte of the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/ahp_front.sv =====
`timescale 1ns / 1ps

module ahp_front
    import ahp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_head_valid,
    output t_qent    o_head,
    input  logic     i_pop
);

    t_qent             r_ent [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;
    t_qent             w_new;

    // An end marker carries no byte; its data is dropped here.
    always_comb begin
        if (i_in_data.end_of_data) begin
            w_new.kind      = KIND_END;
            w_new.data_byte = 8'd0;
        end else begin
            w_new.kind      = KIND_BYTE;
            w_new.data_byte = i_in_data.data_byte;
        end
    end

    assign o_in_ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push       = i_in_valid && o_in_ready;
    assign o_head_valid = (r_count != '0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_ent[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wptr] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!w_push && w_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/ahp_back.sv =====
`timescale 1ns / 1ps

module ahp_back
    import ahp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_qent     i_head,
    output logic      o_pop,
    input  logic [7:0] i_file_type,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_hdr [FIXED_HEADER_BYTES];
    logic [31:0]      r_crc;
    logic [15:0]      r_left;
    logic             r_in_name;
    logic             r_pad;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [POS_W-1:0] n_pos;
    logic [31:0]      n_crc;
    logic [15:0]      n_left;
    logic             n_in_name;
    logic             n_pad;

    logic [7:0]  w_view [FIXED_HEADER_BYTES];
    logic [31:0] w_crc_upd;
    logic        w_out_free;
    logic        w_hdr_wr;
    logic        w_emit;
    logic [2:0]  w_status;
    logic [15:0] w_stored_crc;
    logic [15:0] w_head_size;
    logic [15:0] w_name_len;
    logic        w_size_bad;
    logic        w_type_bad;
    logic        w_crc_ok_old;
    logic        w_crc_ok_new;
    t_out_item   w_fields;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_stored_crc = {r_hdr[1], r_hdr[0]};
    assign w_head_size  = {r_hdr[6], r_hdr[5]};
    assign w_name_len   = {r_hdr[27], r_hdr[26]};
    assign w_size_bad   = (w_head_size < MIN_HEAD_SIZE);
    assign w_type_bad   = (r_hdr[2] != i_file_type);

    // One CRC unit, shared by header bytes, name bytes and zero padding.
    assign w_crc_upd    = crc_byte(r_crc, r_pad ? 8'd0 : i_head.data_byte);
    assign w_crc_ok_old = ((~r_crc[15:0]) == w_stored_crc);
    assign w_crc_ok_new = ((~w_crc_upd[15:0]) == w_stored_crc);

    // Header bytes as they stand once this cycle's byte is written.
    always_comb begin
        for (int i = 0; i < FIXED_HEADER_BYTES; i++) begin
            w_view[i] = (w_hdr_wr && (r_pos == POS_W'(i))) ? i_head.data_byte : r_hdr[i];
        end
    end

    always_comb begin
        w_fields.block_flags    = {w_view[4], w_view[3]};
        w_fields.header_size    = {w_view[6], w_view[5]};
        w_fields.packed_size    = {w_view[10], w_view[9], w_view[8], w_view[7]};
        w_fields.unpacked_size  = {w_view[14], w_view[13], w_view[12], w_view[11]};
        w_fields.host_system    = w_view[15];
        w_fields.content_crc    = {w_view[19], w_view[18], w_view[17], w_view[16]};
        w_fields.packed_time    = {w_view[23], w_view[22], w_view[21], w_view[20]};
        w_fields.unpack_version = w_view[24];
        w_fields.pack_method    = w_view[25];
        w_fields.name_length    = {w_view[27], w_view[26]};
        w_fields.attributes     = {w_view[31], w_view[30], w_view[29], w_view[28]};
        w_fields.status         = w_status;
    end

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_left    = r_left;
        n_in_name = r_in_name;
        n_pad     = r_pad;
        w_hdr_wr  = 1'b0;
        w_emit    = 1'b0;
        w_status  = ST_OK;
        o_pop     = 1'b0;
        priority if (r_pad) begin
            // Missing header bytes enter the CRC as zeros.
            if (r_pos != LAST_POS) begin
                n_crc = w_crc_upd;
                n_pos = r_pos + POS_W'(1);
            end else if (w_out_free) begin
                w_emit = 1'b1;
                o_pop  = 1'b1;
                priority if (w_size_bad) begin
                    w_status = ST_BROKEN;
                end else if (w_type_bad) begin
                    w_status = ST_OTHER;
                end else begin
                    w_status = w_crc_ok_new ? ST_OK : ST_CRC_BAD;
                end
            end
        end else if (i_head_valid && (i_head.kind == KIND_END)) begin
            priority if (r_in_name) begin
                if (w_out_free) begin
                    w_emit   = 1'b1;
                    o_pop    = 1'b1;
                    w_status = w_crc_ok_old ? ST_OK : ST_CRC_BAD;
                end
            end else if (r_pos == '0) begin
                if (w_out_free) begin
                    w_emit   = 1'b1;
                    o_pop    = 1'b1;
                    w_status = ST_END;
                end
            end else if ({{(16-POS_W){1'b0}}, r_pos} < MIN_HEAD_SIZE) begin
                if (w_out_free) begin
                    w_emit   = 1'b1;
                    o_pop    = 1'b1;
                    w_status = ST_BROKEN;
                end
            end else begin
                n_pad = 1'b1;
            end
        end else if (i_head_valid) begin
            priority if (r_in_name) begin
                if (r_left != 16'd1) begin
                    n_crc  = w_crc_upd;
                    n_left = r_left - 16'd1;
                    o_pop  = 1'b1;
                end else if (w_out_free) begin
                    w_emit   = 1'b1;
                    o_pop    = 1'b1;
                    w_status = w_crc_ok_new ? ST_OK : ST_CRC_BAD;
                end
            end else if (r_pos != LAST_POS) begin
                w_hdr_wr = 1'b1;
                o_pop    = 1'b1;
                n_pos    = r_pos + POS_W'(1);
                if (r_pos >= CRC_FIRST_POS) begin
                    n_crc = w_crc_upd;
                end
            end else if (w_out_free) begin
                // Last fixed header byte: decide on the block.
                w_hdr_wr = 1'b1;
                o_pop    = 1'b1;
                n_crc    = w_crc_upd;
                priority if (w_size_bad) begin
                    w_emit   = 1'b1;
                    w_status = ST_BROKEN;
                end else if (w_type_bad) begin
                    w_emit   = 1'b1;
                    w_status = ST_OTHER;
                end else if (w_name_len == 16'd0) begin
                    w_emit   = 1'b1;
                    w_status = w_crc_ok_new ? ST_OK : ST_CRC_BAD;
                end else begin
                    n_in_name = 1'b1;
                    n_left    = w_name_len;
                end
            end else begin
                // The last header byte waits until the output register is free.
            end
        end else begin
            // Nothing queued: the parser holds its state.
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_emit) begin
            for (int i = 0; i < FIXED_HEADER_BYTES; i++) begin
                r_hdr[i] <= 8'd0;
            end
        end else if (w_hdr_wr) begin
            r_hdr[r_pos] <= i_head.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_emit) begin
            r_pos     <= '0;
            r_crc     <= CRC_INIT;
            r_left    <= 16'd0;
            r_in_name <= 1'b0;
            r_pad     <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_left    <= n_left;
            r_in_name <= n_in_name;
            r_pad     <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_fields;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/archive_file_header_parser.sv =====
`timescale 1ns / 1ps

// Archive file header parser.
// The input channel (i_in_valid, o_in_ready, i_in_data) carries one stream byte per
// transfer, or an end-of-data marker whose byte is ignored. Each block yields exactly one
// result transfer on the output channel (o_out_valid, i_out_ready, o_out_data): the
// decoded 32-byte fixed header and a status (ok, CRC mismatch, broken, other block type
// or end of archive). The CRC-32 over header bytes 2 to 31 and, for file headers, the
// name bytes is checked against the stored 16-bit header CRC.
// Bytes are taken at one per cycle unless the queue is full. The last byte or end marker of
// a block passes through the queue, and the result is then registered in the output register.
// An end marker after 7 to 31 header bytes feeds the missing bytes into the CRC as zeros,
// one byte per cycle through the single CRC unit.
// A two-entry queue separates the input side from the parser, and the result sits in an
// output register, so a new byte is taken while a result waits for the receiver. When the
// receiver stalls, the parser stops on reaching the last fixed header byte or the end of a
// block while the previous result still waits; the queue then fills and o_in_ready falls.
// i_cfg_we writes i_cfg_data as the file block type; the user must write it only while idle,
// which the block does not enforce. The synchronous active-low reset empties the queue and
// the output register, clears the header and CRC state and sets the file block type to 116.

module archive_file_header_parser
    import ahp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    // The configured type byte that marks a file header followed by its name.
    logic [7:0] r_file_type;

    // Head of the queue as seen by the parser.
    logic  w_head_valid;
    t_qent w_head;
    logic  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_type <= FILE_TYPE_RST;
        end else if (i_cfg_we) begin
            r_file_type <= i_cfg_data;
        end
    end

    // The front classifies each transfer as a byte or an end marker and queues it.
    ahp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // The back gathers the header, runs the CRC and delivers the result.
    ahp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_file_type  (r_file_type),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== hw/rtl/ahp_checker.sv =====
`timescale 1ns / 1ps

module ahp_checker
    import ahp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input t_in_item   i_in_data,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_item  o_out_data,
    input logic       i_cfg_we,
    input logic [7:0] i_cfg_data
);

    // A waiting result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or vanished while stalled");

    // No result is left over from before a reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_END))
        else $error("status code out of range");

    // End of archive comes only before any header byte, so all fields are zero.
    a_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_END) |->
            (o_out_data.header_size == 16'd0) && (o_out_data.block_flags == 16'd0) &&
            (o_out_data.name_length == 16'd0) && (o_out_data.attributes == 32'd0))
        else $error("end of archive with header data");

    // A judged header has passed the size check.
    a_size_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.status == ST_OK) || (o_out_data.status == ST_CRC_BAD) ||
            (o_out_data.status == ST_OTHER)) |-> (o_out_data.header_size >= MIN_HEAD_SIZE))
        else $error("header judged despite a short header size");

endmodule

bind archive_file_header_parser ahp_checker u_ahp_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Bench for the archive file header parser.
//
// Stream bytes are queued by the stimulus process and handed to the block by a
// bursty driver. A monitor tracks every accepted transfer with a software copy of
// the parser and checks each result transfer against the oldest predicted header.
module tb;
    import ahp_pkg::*;

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} t_fill;

    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int LONG_HOLD     = 400;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data  = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_we   = 1'b0;
    logic [7:0] i_cfg_data = '0;

    // Bytes waiting to be offered, and headers the block still owes us.
    t_in_item   pending_bytes[$];
    t_out_item  expected_headers[$];

    // Software copy of the parser state and of its block type register.
    logic [7:0]  hdr_mem [FIXED_HEADER_BYTES];
    int          hdr_pos;
    logic [31:0] hdr_crc;
    logic [15:0] name_left;
    bit          name_phase;
    logic [7:0]  type_setting;

    // Block type that the stimulus currently builds file headers for.
    logic [7:0]  stream_type = FILE_TYPE_RST;

    int errors        = 0;
    int stim_items    = 0;
    int bytes_taken   = 0;
    int results_seen  = 0;
    int type_settings = 1;
    int status_seen [8];

    int holds_asked = 0;
    int holds_seen  = 0;
    int hold_left   = 0;
    int ready_run   = 0;
    int stall_run   = 0;
    int burst_left  = 0;
    int gap_left    = 0;

    t_out_item want;

    archive_file_header_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Header prediction
    // ------------------------------------------------------------------

    // Reflected CRC-32, one byte, least significant bit first.
    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [15:0] hdr_le16(input int i);
        return {hdr_mem[i + 1], hdr_mem[i]};
    endfunction

    function automatic logic [31:0] hdr_le32(input int i);
        return {hdr_le16(i + 2), hdr_le16(i)};
    endfunction

    // The stored header CRC is only the low half of the inverted running CRC.
    function automatic logic [2:0] crc_verdict();
        return (~hdr_crc[15:0] == hdr_le16(0)) ? ST_OK : ST_CRC_BAD;
    endfunction

    // Verdict on a whole header, padded or not. go_name is raised when a file
    // header still has name bytes to come.
    function automatic logic [2:0] judge_header(input bit truncated, output bit go_name);
        go_name = 1'b0;
        if (hdr_le16(5) < MIN_HEAD_SIZE)
            return ST_BROKEN;
        if (hdr_mem[2] != type_setting)
            return ST_OTHER;
        if (truncated || hdr_le16(26) == 16'd0)
            return crc_verdict();
        go_name = 1'b1;
        return ST_OK;
    endfunction

    task automatic clear_block();
        hdr_pos    = 0;
        hdr_crc    = CRC_INIT;
        name_left  = '0;
        name_phase = 1'b0;
        for (int i = 0; i < FIXED_HEADER_BYTES; i++) begin
            hdr_mem[i] = '0;
        end
    endtask

    // Queue the decoded header with its status; after an end at the start of
    // a block the header is still all zero, so every field reads as zero.
    task automatic close_block(input logic [2:0] st);
        t_out_item r;
        r.block_flags    = hdr_le16(3);
        r.header_size    = hdr_le16(5);
        r.packed_size    = hdr_le32(7);
        r.unpacked_size  = hdr_le32(11);
        r.host_system    = hdr_mem[15];
        r.content_crc    = hdr_le32(16);
        r.packed_time    = hdr_le32(20);
        r.unpack_version = hdr_mem[24];
        r.pack_method    = hdr_mem[25];
        r.name_length    = hdr_le16(26);
        r.attributes     = hdr_le32(28);
        r.status         = st;
        expected_headers.push_back(r);
        clear_block();
    endtask

    task automatic track_stream_byte(input t_in_item it);
        logic [2:0] st;
        bit         go_name;
        if (it.end_of_data) begin
            if (name_phase) begin
                close_block(crc_verdict());
            end else if (hdr_pos == 0) begin
                close_block(ST_END);
            end else if (hdr_pos < int'(MIN_HEAD_SIZE)) begin
                close_block(ST_BROKEN);
            end else begin
                // The missing tail of the header counts as zeros, CRC included.
                while (hdr_pos < FIXED_HEADER_BYTES) begin
                    hdr_mem[hdr_pos] = '0;
                    hdr_crc = crc32_step(hdr_crc, 8'd0);
                    hdr_pos++;
                end
                st = judge_header(1'b1, go_name);
                close_block(st);
            end
        end else if (name_phase) begin
            hdr_crc   = crc32_step(hdr_crc, it.data_byte);
            name_left = name_left - 16'd1;
            if (name_left == 16'd0)
                close_block(crc_verdict());
        end else begin
            hdr_mem[hdr_pos] = it.data_byte;
            if (hdr_pos >= int'(CRC_FIRST_POS))
                hdr_crc = crc32_step(hdr_crc, it.data_byte);
            hdr_pos++;
            if (hdr_pos == FIXED_HEADER_BYTES) begin
                st = judge_header(1'b0, go_name);
                if (go_name) begin
                    name_left  = hdr_le16(26);
                    name_phase = 1'b1;
                end else begin
                    close_block(st);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Printing is capped so that a badly broken block cannot flood the log.
    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 100)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s is %h, predicted %h",
                                      results_seen, name, got, exp_val));
    endtask

    // The monitor tracks input transfers before it checks the output, so a
    // prediction is always queued before its result can be compared.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            type_setting = FILE_TYPE_RST;
            clear_block();
        end else begin
            if (i_cfg_we)
                type_setting = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                track_stream_byte(i_in_data);
                bytes_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_headers.size() == 0) begin
                    report_mismatch("result transfer with no header predicted");
                end else begin
                    want = expected_headers.pop_front();
                    check_field("block_flags", 32'(o_out_data.block_flags),
                                32'(want.block_flags));
                    check_field("header_size", 32'(o_out_data.header_size),
                                32'(want.header_size));
                    check_field("packed_size", o_out_data.packed_size, want.packed_size);
                    check_field("unpacked_size", o_out_data.unpacked_size,
                                want.unpacked_size);
                    check_field("host_system", 32'(o_out_data.host_system),
                                32'(want.host_system));
                    check_field("content_crc", o_out_data.content_crc, want.content_crc);
                    check_field("packed_time", o_out_data.packed_time, want.packed_time);
                    check_field("unpack_version", 32'(o_out_data.unpack_version),
                                32'(want.unpack_version));
                    check_field("pack_method", 32'(o_out_data.pack_method),
                                32'(want.pack_method));
                    check_field("name_length", 32'(o_out_data.name_length),
                                32'(want.name_length));
                    check_field("attributes", o_out_data.attributes, want.attributes);
                    check_field("status", 32'(o_out_data.status), 32'(want.status));
                    status_seen[want.status]++;
                    results_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of back-to-back transfers separated by random gaps
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!i_in_valid || o_in_ready) begin
            // Either nothing is on offer or the current byte has just gone.
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                i_in_data  <= pending_bytes.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 48);
                    case ($urandom_range(0, 7))
                        0, 1, 2: gap_left = 0;
                        7:       gap_left = $urandom_range(8, 15);
                        default: gap_left = $urandom_range(1, 4);
                    endcase
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: runs of ready and stalls, plus long hold-offs on request
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left = 0;
            ready_run = 0;
            stall_run = 0;
        end else if (holds_seen != holds_asked) begin
            holds_seen = holds_asked;
            hold_left  = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
            i_out_ready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            i_out_ready <= 1'b0;
        end else begin
            ready_run = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 80);
            case ($urandom_range(0, 7))
                0, 1:    stall_run = 0;
                7:       stall_run = $urandom_range(15, 30);
                default: stall_run = $urandom_range(1, 6);
            endcase
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic offer_byte(input logic [7:0] b, input bit eod);
        t_in_item it;
        it.data_byte   = b;
        it.end_of_data = eod;
        pending_bytes.push_back(it);
        stim_items++;
    endtask

    // The byte travelling with an end marker is don't-care, so it is random.
    task automatic offer_end();
        offer_byte(8'($urandom), 1'b1);
    endtask

    // Builds one block: a 32-byte header with the given type, size and name
    // length, its name, and a stored CRC that matches unless crc_good is low.
    // When cut is not negative and below the block length, only cut bytes are sent and an end
    // marker follows; the header CRC is then worked out over the sent bytes and over the zero
    // padding that the parser puts in place of any missing header bytes.
    task automatic add_block(input logic [7:0] typ, input logic [15:0] hsize,
                             input logic [15:0] nlen, input int cut,
                             input bit crc_good, input t_fill fill);
        logic [7:0]  h [FIXED_HEADER_BYTES];
        logic [7:0]  name_q [$];
        logic [7:0]  nb;
        logic [31:0] c;
        logic [15:0] chk;
        bit          reads_name;
        int          total;
        int          sent;
        for (int i = 0; i < FIXED_HEADER_BYTES; i++) begin
            case (fill)
                FILL_ONES:  h[i] = 8'hFF;
                FILL_ZEROS: h[i] = 8'h00;
                default:    h[i] = 8'($urandom);
            endcase
        end
        h[2]  = typ;
        h[5]  = hsize[7:0];
        h[6]  = hsize[15:8];
        h[26] = nlen[7:0];
        h[27] = nlen[15:8];
        reads_name = (typ == stream_type) && (hsize >= MIN_HEAD_SIZE) && (nlen != 16'd0);
        total = FIXED_HEADER_BYTES + (reads_name ? int'(nlen) : 0);
        sent  = (cut < 0 || cut > total) ? total : cut;
        for (int i = sent; i < FIXED_HEADER_BYTES; i++) begin
            h[i] = 8'h00;
        end
        c = CRC_INIT;
        for (int i = int'(CRC_FIRST_POS); i < FIXED_HEADER_BYTES; i++) begin
            c = crc32_step(c, h[i]);
        end
        for (int i = FIXED_HEADER_BYTES; i < sent; i++) begin
            nb = (fill == FILL_RANDOM) ? 8'($urandom) : h[31];
            name_q.push_back(nb);
            c = crc32_step(c, nb);
        end
        chk = ~c[15:0];
        if (!crc_good)
            chk ^= 16'($urandom_range(1, 65535));
        h[0] = chk[7:0];
        h[1] = chk[15:8];
        for (int i = 0; i < sent && i < FIXED_HEADER_BYTES; i++) begin
            offer_byte(h[i], 1'b0);
        end
        foreach (name_q[i]) begin
            offer_byte(name_q[i], 1'b0);
        end
        if (sent < total)
            offer_end();
    endtask

    function automatic logic [15:0] random_head_size();
        return ($urandom_range(0, 7) == 0) ? MIN_HEAD_SIZE : 16'($urandom_range(7, 65535));
    endfunction

    // Mostly well-formed file headers with random content, so that the name
    // phase and the CRC check are reached often; the rest are other block
    // types, undersized headers, long names cut short, noise and bare ends.
    task automatic random_phase(input int n_items);
        int          goal;
        int          pick;
        int          cut;
        int          noise_len;
        logic [15:0] nlen;
        goal = stim_items + n_items;
        while (stim_items < goal) begin
            pick = $urandom_range(0, 99);
            nlen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(9, 40))
                                               : 16'($urandom_range(0, 8));
            cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32 + nlen) : -1;
            if (pick < 60) begin
                add_block(stream_type, random_head_size(), nlen, cut,
                          $urandom_range(0, 6) != 0, FILL_RANDOM);
            end else if (pick < 70) begin
                add_block(8'($urandom), random_head_size(), nlen, cut, 1'b1, FILL_RANDOM);
            end else if (pick < 78) begin
                add_block(stream_type, 16'($urandom_range(0, 6)), nlen, cut, 1'b1,
                          FILL_RANDOM);
            end else if (pick < 83) begin
                add_block(stream_type, random_head_size(), 16'hFFFF,
                          $urandom_range(32, 48), 1'b1, FILL_RANDOM);
            end else if (pick < 95) begin
                // Noise is closed by an end marker so that the following
                // well-formed blocks line up with the parser again.
                noise_len = $urandom_range(1, 40);
                repeat (noise_len) offer_byte(8'($urandom), 1'b0);
                offer_end();
            end else begin
                offer_end();
            end
        end
        offer_end();
    endtask

    function automatic bit stream_busy();
        return pending_bytes.size() != 0 || i_in_valid || expected_headers.size() != 0;
    endfunction

    // Sampled at the falling edge, when every update of the rising edge has
    // settled. The settle time covers the zero padding after a short header.
    task automatic wait_idle();
        while (stream_busy()) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Only called while idle, so no block is part-way through a header.
    task automatic write_file_type(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        stream_type = v;
        type_settings++;
    endtask

    initial begin
        int spin;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases at the reset block type.
        offer_end();                                                  // end of archive
        add_block(FILE_TYPE_RST, 16'd32, 16'd0, -1, 1'b1, FILL_RANDOM);   // empty name
        add_block(FILE_TYPE_RST, 16'd40, 16'd3, -1, 1'b1, FILL_RANDOM);   // good name
        add_block(FILE_TYPE_RST, 16'd40, 16'd5, -1, 1'b0, FILL_RANDOM);   // bad CRC
        add_block(FILE_TYPE_RST, 16'd6, 16'd4, -1, 1'b1, FILL_RANDOM);    // size too small
        add_block(8'h73, 16'd13, 16'd4, -1, 1'b1, FILL_RANDOM);           // other type
        add_block(FILE_TYPE_RST, 16'd7, 16'd2, 1, 1'b1, FILL_RANDOM);     // end after 1
        add_block(FILE_TYPE_RST, 16'd7, 16'd2, 6, 1'b1, FILL_RANDOM);     // end after 6
        add_block(FILE_TYPE_RST, 16'd7, 16'd2, 7, 1'b1, FILL_RANDOM);     // padded from 7
        add_block(FILE_TYPE_RST, 16'd200, 16'd9, 31, 1'b0, FILL_RANDOM);  // padded from 31
        add_block(FILE_TYPE_RST, 16'hFFFF, 16'hFFFF, 40, 1'b1, FILL_ONES); // end in name
        add_block(8'hFF, 16'hFFFF, 16'hFFFF, -1, 1'b1, FILL_ONES);        // all ones
        add_block(8'h00, 16'd0, 16'd0, -1, 1'b1, FILL_ZEROS);             // all zeros
        offer_end();
        offer_end();
        wait_idle();

        // Block type at its lowest; all-zero headers now count as file headers.
        write_file_type(8'h00);
        add_block(8'h00, 16'd7, 16'd0, -1, 1'b1, FILL_ZEROS);
        random_phase(240);
        wait_idle();

        // Highest block type, with the sender paused half way until every
        // result owed so far has come back.
        write_file_type(8'hFF);
        random_phase(112);
        wait_idle();
        random_phase(112);
        wait_idle();

        // The receiver holds off for a long stretch while bytes keep coming,
        // so the input queue fills and the block has to refuse transfers.
        write_file_type(8'($urandom));
        random_phase(240);
        holds_asked++;
        wait_idle();

        write_file_type(FILE_TYPE_RST);
        random_phase(240);
        wait_idle();

        write_file_type(8'($urandom));
        random_phase(240);

        spin = 0;
        while (stream_busy() && spin < DRAIN_LIMIT) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_headers.size() != 0)
            report_mismatch($sformatf("%0d predicted headers never came out",
                                      expected_headers.size()));

        $display("Run took %0d stream transfers under %0d block type settings and checked",
                 bytes_taken, type_settings);
        $display("%0d headers: %0d ok, %0d bad CRC, %0d broken, %0d other type, %0d end.",
                 results_seen, status_seen[ST_OK], status_seen[ST_CRC_BAD],
                 status_seen[ST_BROKEN], status_seen[ST_OTHER], status_seen[ST_END]);
        if (errors == 0) begin
            $display("archive_file_header_parser verification clean");
        end else begin
            $display("archive_file_header_parser verification failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run: every byte after the longest gap,
    // every result after the longest stall and a full padding pass.
    initial begin
        #20000000;
        $display("archive_file_header_parser verification failed");
        $finish;
    end

endmodule
